@@ design/bfa_pkg.sv @@
`timescale 1ns / 1ps
package bfa_pkg;

    localparam int RES_BITS    = 16;
    localparam int MAX_NODES   = 256;
    localparam int NODE_AW     = 8;
    localparam int NODE_CW     = 9;
    localparam int MAX_JOBS    = 1024;
    localparam int JOB_AW      = 10;
    localparam int JOB_CW      = 11;
    localparam int ID_W        = 11;
    localparam int NUM_FLAVORS = 4;
    localparam int FLAV_W      = 2;
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLAVOR_COUNT = 3'd0,
        REG_FLAVOR_0     = 3'd1,
        REG_FLAVOR_1     = 3'd2,
        REG_FLAVOR_2     = 3'd3,
        REG_FLAVOR_3     = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FLAVOR = 2'd1,
        ST_FULL      = 2'd2,
        ST_NO_JOB    = 2'd3
    } status_t;

    typedef struct packed {
        logic                mode;
        logic [ID_W-1:0]     job_id;
        logic [RES_BITS-1:0] need_cpu;
        logic [RES_BITS-1:0] need_memory;
    } in_item_t;

    typedef struct packed {
        logic [NODE_AW-1:0] node_index;
        logic               opened_node;
        logic [FLAV_W-1:0]  opened_flavor;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic [RES_BITS-1:0] free_cpu;
        logic [RES_BITS-1:0] free_mem;
        logic [RES_BITS-1:0] used_cpu;
        logic [RES_BITS-1:0] used_mem;
        logic                open;
    } node_entry_t;

    typedef struct packed {
        logic [RES_BITS-1:0] cpu;
        logic [RES_BITS-1:0] mem;
        logic [NODE_AW-1:0]  node;
        logic                live;
    } job_entry_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    node_read;
        logic    scan_start;
        logic    wr_delete;
        logic    wr_place;
        logic    wr_open;
        logic    err_load;
        status_t err_code;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic out_free;
        logic id_bad;
        logic is_delete;
        logic job_live;
        logic scan_done;
        logic found;
        logic flav_found;
        logic table_full;
    } stat_t;

endpackage

@@ design/bfa_ctrl.sv @@
`timescale 1ns / 1ps
module bfa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bfa_pkg::stat_t stat,
    output bfa_pkg::cmd_t  cmd
);
    import bfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_JOB_WAIT,
        S_JOB_CHK,
        S_NODE_WAIT,
        S_NODE_UPD,
        S_SCAN,
        S_DECIDE
    } state_t;

    state_t state_reg, state_next;

    // decode commands and next state
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.err_code = ST_OK;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = stat.clear_done;
                if (in_valid && stat.clear_done)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_JOB_WAIT;
                end
            end
            S_JOB_WAIT:
                state_next = S_JOB_CHK;
            S_JOB_CHK:
            begin
                if (stat.id_bad || (stat.is_delete != stat.job_live))
                begin
                    if (stat.out_free)
                    begin
                        cmd.err_load = 1'b1;
                        cmd.err_code = ST_NO_JOB;
                        state_next   = S_IDLE;
                    end
                end
                else if (stat.is_delete)
                begin
                    cmd.node_read = 1'b1;
                    state_next    = S_NODE_WAIT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_NODE_WAIT:
                state_next = S_NODE_UPD;
            S_NODE_UPD:
            begin
                if (stat.out_free)
                begin
                    cmd.wr_delete = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                    priority if (stat.found)
                        cmd.wr_place = 1'b1;
                    else if (!stat.flav_found)
                    begin
                        cmd.err_load = 1'b1;
                        cmd.err_code = ST_NO_FLAVOR;
                    end
                    else if (stat.table_full)
                    begin
                        cmd.err_load = 1'b1;
                        cmd.err_code = ST_FULL;
                    end
                    else
                        cmd.wr_open = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE && stat.clear_done)
        else $error("ready outside idle");
    a_load_advance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_JOB_WAIT)
        else $error("load did not advance");
    a_scan_then_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> state_reg == S_SCAN)
        else $error("scan start lost");
`endif
endmodule

@@ design/bfa_datapath.sv @@
`timescale 1ns / 1ps
module bfa_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bfa_pkg::in_item_t                 in_data,
    input  logic                              cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfa_pkg::CFG_W-1:0]         cfg_data,
    input  bfa_pkg::cmd_t                     cmd,
    output bfa_pkg::stat_t                    stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bfa_pkg::out_item_t                out_data
);
    import bfa_pkg::*;

    // configuration
    logic [2:0]       flavor_count_reg;
    logic [CFG_W-1:0] flavor_word_reg [NUM_FLAVORS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flavor_count_reg <= 3'd1;
            for (int k = 0; k < NUM_FLAVORS; k++)
                flavor_word_reg[k] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FLAVOR_COUNT: flavor_count_reg   <= cfg_data[2:0];
                REG_FLAVOR_0:     flavor_word_reg[0] <= cfg_data;
                REG_FLAVOR_1:     flavor_word_reg[1] <= cfg_data;
                REG_FLAVOR_2:     flavor_word_reg[2] <= cfg_data;
                REG_FLAVOR_3:     flavor_word_reg[3] <= cfg_data;
                default:          ;
            endcase
        end
    end

    // latched item
    in_item_t item_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_data;
    end

    // memories
    node_entry_t node_mem [MAX_NODES];
    job_entry_t  job_mem  [MAX_JOBS];
    node_entry_t node_q_reg;
    job_entry_t  job_q_reg;

    logic [NODE_AW-1:0] node_raddr, node_waddr;
    logic               node_re, node_we;
    node_entry_t        node_wdata;
    logic [JOB_AW-1:0]  job_waddr, slot_in, slot;
    logic               job_we;
    job_entry_t         job_wdata;

    logic [JOB_CW-1:0] clr_cnt_reg;
    logic              clear_done;
    assign clear_done = clr_cnt_reg[JOB_CW-1];

    assign slot_in = JOB_AW'(in_data.job_id - ID_W'(1));
    assign slot    = JOB_AW'(item_reg.job_id - ID_W'(1));

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        if (node_re)
            node_q_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (job_we)
            job_mem[job_waddr] <= job_wdata;
        if (cmd.load)
            job_q_reg <= job_mem[slot_in];
    end

    // sweep the job table clear after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (!clear_done)
            clr_cnt_reg <= clr_cnt_reg + JOB_CW'(1);
    end

    // scan of open nodes
    logic [NODE_CW-1:0]  niu_reg, scan_cnt_reg;
    logic                scan_act_reg, eval_vld_reg, found_reg;
    logic [NODE_AW-1:0]  eval_idx_reg, best_idx_reg;
    logic [RES_BITS-1:0] best_fit_reg;
    node_entry_t         best_reg;
    logic                scan_issue;
    logic                fits, better;
    logic [RES_BITS-1:0] lc, lm, fit;

    assign scan_issue = scan_act_reg && (scan_cnt_reg < niu_reg);
    assign fits = node_q_reg.open && node_q_reg.free_cpu >= item_reg.need_cpu
                  && node_q_reg.free_mem >= item_reg.need_memory;
    assign lc     = node_q_reg.free_cpu - item_reg.need_cpu;
    assign lm     = node_q_reg.free_mem - item_reg.need_memory;
    assign fit    = (lc > lm) ? lc : lm;
    assign better = eval_vld_reg && fits && (!found_reg || fit < best_fit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_act_reg <= 1'b0;
            eval_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            scan_cnt_reg <= '0;
        end
        else if (cmd.scan_start)
        begin
            scan_act_reg <= 1'b1;
            eval_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            scan_cnt_reg <= '0;
        end
        else
        begin
            eval_vld_reg <= scan_issue;
            if (scan_issue)
                scan_cnt_reg <= scan_cnt_reg + NODE_CW'(1);
            else
                scan_act_reg <= 1'b0;
            if (better)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_issue)
            eval_idx_reg <= scan_cnt_reg[NODE_AW-1:0];
        if (better)
        begin
            best_fit_reg <= fit;
            best_idx_reg <= eval_idx_reg;
            best_reg     <= node_q_reg;
        end
    end

    // cheapest flavor that holds the job
    logic [2:0]          fcount;
    logic                flav_found;
    logic [FLAV_W-1:0]   flav_sel;
    logic [RES_BITS-1:0] flav_cpu, flav_mem, flav_price;

    assign fcount = (flavor_count_reg > 3'(NUM_FLAVORS)) ? 3'(NUM_FLAVORS)
                                                        : flavor_count_reg;

    always_comb
    begin
        flav_found = 1'b0;
        flav_sel   = '0;
        flav_cpu   = '0;
        flav_mem   = '0;
        flav_price = '0;
        for (int k = 0; k < NUM_FLAVORS; k++)
        begin
            if (3'(k) < fcount
                && flavor_word_reg[k][47:32] >= item_reg.need_cpu
                && flavor_word_reg[k][31:16] >= item_reg.need_memory
                && (!flav_found || flavor_word_reg[k][15:0] < flav_price))
            begin
                flav_found = 1'b1;
                flav_sel   = FLAV_W'(k);
                flav_cpu   = flavor_word_reg[k][47:32];
                flav_mem   = flavor_word_reg[k][31:16];
                flav_price = flavor_word_reg[k][15:0];
            end
        end
    end

    // node port: address and write data per command
    always_comb
    begin
        node_re    = scan_issue || cmd.node_read;
        node_raddr = cmd.node_read ? job_q_reg.node : scan_cnt_reg[NODE_AW-1:0];
        node_we    = cmd.wr_delete || cmd.wr_place || cmd.wr_open;
        node_waddr = job_q_reg.node;
        node_wdata = node_q_reg;
        priority if (cmd.wr_delete)
        begin
            node_wdata.used_cpu = node_q_reg.used_cpu - job_q_reg.cpu;
            node_wdata.used_mem = node_q_reg.used_mem - job_q_reg.mem;
            node_wdata.free_cpu = node_q_reg.free_cpu + job_q_reg.cpu;
            node_wdata.free_mem = node_q_reg.free_mem + job_q_reg.mem;
            node_wdata.open     = node_q_reg.open
                                  && !(node_wdata.used_cpu == '0 && node_wdata.used_mem == '0);
        end
        else if (cmd.wr_place)
        begin
            node_waddr          = best_idx_reg;
            node_wdata          = best_reg;
            node_wdata.free_cpu = best_reg.free_cpu - item_reg.need_cpu;
            node_wdata.free_mem = best_reg.free_mem - item_reg.need_memory;
            node_wdata.used_cpu = best_reg.used_cpu + item_reg.need_cpu;
            node_wdata.used_mem = best_reg.used_mem + item_reg.need_memory;
        end
        else
        begin
            node_waddr          = niu_reg[NODE_AW-1:0];
            node_wdata.free_cpu = flav_cpu - item_reg.need_cpu;
            node_wdata.free_mem = flav_mem - item_reg.need_memory;
            node_wdata.used_cpu = item_reg.need_cpu;
            node_wdata.used_mem = item_reg.need_memory;
            node_wdata.open     = 1'b1;
        end
    end

    // job port: clearing sweep or commit
    always_comb
    begin
        job_we         = !clear_done || cmd.wr_delete || cmd.wr_place || cmd.wr_open;
        job_waddr      = clear_done ? slot : clr_cnt_reg[JOB_AW-1:0];
        job_wdata.cpu  = item_reg.need_cpu;
        job_wdata.mem  = item_reg.need_memory;
        job_wdata.node = cmd.wr_place ? best_idx_reg : niu_reg[NODE_AW-1:0];
        job_wdata.live = 1'b1;
        if (!clear_done)
            job_wdata = '0;
        else if (cmd.wr_delete)
        begin
            job_wdata      = job_q_reg;
            job_wdata.live = 1'b0;
        end
    end

    // node count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            niu_reg <= '0;
        else if (cmd.wr_open)
            niu_reg <= niu_reg + NODE_CW'(1);
    end

    // result register
    logic      out_valid_reg;
    out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (node_we || cmd.err_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (node_we || cmd.err_load)
        begin
            out_data_reg.node_index    <= cmd.err_load ? '0 : node_waddr;
            out_data_reg.opened_node   <= cmd.wr_open;
            out_data_reg.opened_flavor <= cmd.wr_open ? flav_sel : '0;
            out_data_reg.status        <= cmd.err_load ? cmd.err_code : ST_OK;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // status to controller
    always_comb
    begin
        stat.clear_done = clear_done;
        stat.out_free   = !out_valid_reg;
        stat.id_bad     = (item_reg.job_id == '0) || (item_reg.job_id > ID_W'(MAX_JOBS));
        stat.is_delete  = item_reg.mode;
        stat.job_live   = job_q_reg.live;
        stat.scan_done  = !scan_act_reg && !eval_vld_reg;
        stat.found      = found_reg;
        stat.flav_found = flav_found;
        stat.table_full = (niu_reg == NODE_CW'(MAX_NODES));
    end

`ifndef SYNTHESIS
    a_one_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_delete, cmd.wr_place, cmd.wr_open, cmd.err_load}))
        else $error("more than one commit");
    a_niu_range: assert property (@(posedge clk) disable iff (!rst_n)
        niu_reg <= NODE_CW'(MAX_NODES))
        else $error("node count overflow");
    a_open_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_open |-> flav_found && niu_reg != NODE_CW'(MAX_NODES))
        else $error("open without room");
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (node_we || cmd.err_load) |-> !out_valid_reg && clear_done)
        else $error("result overwritten");
`endif
endmodule

@@ design/best_fit_two_resource_allocator.sv @@
`timescale 1ns / 1ps
// Best-fit job placer over up to 256 nodes and 1024 job slots. A create beat
// scans every node opened so far, one node per cycle through the node table's
// read port; a bad job id or a job in the wrong live state is answered with
// ST_NO_JOB. A create that ends in an error still pays for its scan. One item
// is worked at a time; a new item can be taken while the previous result still
// waits at the output, but the next result is held until that one is taken.
// After reset the job table is swept clear, during which in_ready stays low;
// configuration writes are taken at any time but must be made while idle.
module best_fit_two_resource_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bfa_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bfa_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfa_pkg::CFG_W-1:0]     cfg_data
);
    import bfa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule
